### hw/rtl/permuted_harary_neighbor_lookup_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the relabelled ring neighbour lookup
// Both macros expect signals named clk and rst_n in the calling scope.
// ----------------------------------------------------------------------------
`ifndef PERMUTED_HARARY_NEIGHBOR_LOOKUP_CORE_MACROS_SVH
`define PERMUTED_HARARY_NEIGHBOR_LOOKUP_CORE_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define PHNL_ASSERT_SAME(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("%m: same-cycle check failed");

// Consequence must hold in the cycle after the antecedent.
`define PHNL_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("%m: next-cycle check failed");

`endif

### hw/rtl/phnl_pkg.sv
// ----------------------------------------------------------------------------
// phnl_pkg
// Shared types and constants of the relabelled ring neighbour lookup.
// ----------------------------------------------------------------------------
package phnl_pkg;

    localparam int FIELD_W    = 10;
    localparam int CFG_NC_W   = 11;
    localparam int CFG_DEG_W  = 10;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;
    // Magnitude of the ring step before reduction: at most 1534
    localparam int MAG_W      = 11;
    localparam int DIV_CNT_W  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE     = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD     = 2'd0,
        OP_NEIGHBOR = 2'd1,
        OP_PAIR     = 2'd2
    } op_e;

    typedef struct packed {
        logic [1:0]         operation;
        logic [FIELD_W-1:0] slot;
        logic [FIELD_W-1:0] label;
        logic [FIELD_W-1:0] node_first;
        logic [FIELD_W-1:0] node_second;
        logic [FIELD_W-1:0] neighbor_pos;
    } req_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] neighbor_node;
        logic [FIELD_W-1:0] position;
        logic               connected;
        logic               outgoing;
        logic               status;
    } rsp_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_INV_A,
        ST_INV_B,
        ST_PAIR,
        ST_DIV,
        ST_FWD_RD,
        ST_FWD_CAP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic write_tables;
        logic inv_rd;
        logic inv_second;
        logic latch_a;
        logic latch_b;
        logic set_err;
        logic div_start;
        logic div_step;
        logic fwd_rd;
        logic latch_neighbor;
        logic latch_pair;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       req_err;
        logic       a_bad;
        logic       pair_bad;
        logic       div_done;
        logic       out_free;
    } sts_t;

endpackage

### hw/rtl/permuted_harary_neighbor_lookup_core.sv
// ----------------------------------------------------------------------------
// permuted_harary_neighbor_lookup_core
// Relabelled circulant graph: table loads, neighbour and pair queries.
// ----------------------------------------------------------------------------
// Usage
//   req channel (req_valid / req_stall / req_data) carries one transaction:
//   a table load, a neighbour query or a pair query. rsp channel
//   (rsp_valid / rsp_stall / rsp_data) returns exactly one result for each.
//   cfg_we / cfg_index / cfg_data write node_count (index 0) and degree
//   (index 1); write them only while no transaction is in flight.
// Sequence (accept edge to result in the output register):
//   load, or any range error found at decode   : decode, done
//   neighbour query on a stale inverse entry   : decode, inverse read, done
//   pair query                                 : decode, both inverse reads,
//     pair check, done; neighbour query: decode, inverse read, the
//     11-step restoring remainder that wraps the ring step onto node_count,
//     forward read and capture, done
//   Back in idle after the hand-over, the sequencer accepts the next one.
// Reset clears the sequencer, the output valid, node_count to 1 and degree
//   to 0. The tables are not cleared and hold garbage until loaded.
// A stalled result holds in the output register; the next transaction is
//   still accepted and worked on, then waits in its final state for the slot.
// ----------------------------------------------------------------------------
module permuted_harary_neighbor_lookup_core #(
    parameter int MAX_NODES = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [phnl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [phnl_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  phnl_pkg::req_item_t                 req_data,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output phnl_pkg::rsp_item_t                 rsp_data
);
    import phnl_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic ready;

    // Sequencer: one transaction at a time
    phnl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .ready     (ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Tables, arithmetic and output register
    phnl_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_data  (req_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data)
    );

    // Hold off new requests until the sequencer is back in idle
    assign req_stall = !ready;

endmodule

### hw/rtl/phnl_ram.sv
// ----------------------------------------------------------------------------
// phnl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module phnl_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/phnl_ctrl.sv
// ----------------------------------------------------------------------------
// phnl_ctrl
// Sequencer: steps one transaction through decode, table reads, division
// and result hand-over.
// ----------------------------------------------------------------------------
module phnl_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           ready,
    input  phnl_pkg::sts_t sts,
    output phnl_pkg::cmd_t cmd
);
    import phnl_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.req_err)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    unique case (sts.op)
                        OP_NEIGHBOR: state_next = ST_INV_A;
                        OP_PAIR:     state_next = ST_INV_A;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_INV_A:
            begin
                if (sts.op == OP_PAIR)
                begin
                    state_next = ST_INV_B;
                end
                else if (sts.a_bad)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_INV_B:   state_next = ST_PAIR;
            ST_PAIR:    state_next = ST_DONE;
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_FWD_RD;
                end
            end
            ST_FWD_RD:  state_next = ST_FWD_CAP;
            ST_FWD_CAP: state_next = ST_DONE;
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd   = '0;
        ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ready       = 1'b1;
                cmd.capture = req_valid;
            end
            ST_DECODE:
            begin
                if (sts.req_err)
                begin
                    cmd.set_err = 1'b1;
                end
                else
                begin
                    unique case (sts.op)
                        OP_LOAD:     cmd.write_tables = 1'b1;
                        OP_NEIGHBOR: cmd.inv_rd = 1'b1;
                        OP_PAIR:     cmd.inv_rd = 1'b1;
                        default:     cmd.set_err = 1'b1;
                    endcase
                end
            end
            ST_INV_A:
            begin
                cmd.latch_a = 1'b1;
                if (sts.op == OP_PAIR)
                begin
                    cmd.inv_rd     = 1'b1;
                    cmd.inv_second = 1'b1;
                end
                else if (sts.a_bad)
                begin
                    cmd.set_err = 1'b1;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                end
            end
            ST_INV_B:
            begin
                cmd.latch_b = 1'b1;
            end
            ST_PAIR:
            begin
                if (sts.pair_bad)
                begin
                    cmd.set_err = 1'b1;
                end
                else
                begin
                    cmd.latch_pair = 1'b1;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_FWD_RD:
            begin
                cmd.fwd_rd = 1'b1;
            end
            ST_FWD_CAP:
            begin
                cmd.latch_neighbor = 1'b1;
            end
            ST_DONE:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### hw/rtl/phnl_dp.sv
// ----------------------------------------------------------------------------
// phnl_dp
// Datapath: configuration registers, relabelling tables, ring-step
// remainder unit, pair distance logic and the output register.
// ----------------------------------------------------------------------------
`include "permuted_harary_neighbor_lookup_core_macros.svh"

module phnl_dp #(
    parameter int MAX_NODES = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [phnl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [phnl_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  phnl_pkg::req_item_t                 req_data,
    input  phnl_pkg::cmd_t                      cmd,
    output phnl_pkg::sts_t                      sts,
    input  logic                                rsp_stall,
    output logic                                rsp_valid,
    output phnl_pkg::rsp_item_t                 rsp_data
);
    import phnl_pkg::*;

    localparam int AW = $clog2(MAX_NODES);
    localparam int NW = $clog2(MAX_NODES + 1);
    localparam int CW = (NW > CFG_NC_W) ? NW : CFG_NC_W;
    localparam int BW = CW + 1;
    localparam int TW = MAG_W + 2;

    logic [CFG_NC_W-1:0]  node_count_reg;
    logic [CFG_DEG_W-1:0] degree_reg;
    req_item_t            item_reg;

    logic [CW-1:0]        n_ext;
    logic [NW-1:0]        n_live;
    logic [CFG_DEG_W-2:0] half;
    logic                 req_err;

    logic [FIELD_W-1:0]   inv_rdata;
    logic [FIELD_W-1:0]   fwd_rdata;
    logic [AW-1:0]        inv_raddr;
    logic [AW-1:0]        fwd_raddr;

    logic [FIELD_W-1:0]   a_reg;
    logic [FIELD_W-1:0]   b_reg;

    logic [TW-1:0]        step_sum;
    logic [TW-1:0]        step_abs;
    logic                 step_neg;
    logic [MAG_W-1:0]     mag_reg;
    logic                 neg_reg;
    logic [NW-1:0]        rem_reg;
    logic [NW-1:0]        rem_next;
    logic [NW:0]          trial;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [NW-1:0]        fwd_index;

    logic [FIELD_W-1:0]   sub_ab;
    logic [CW-1:0]        sub_ext;
    logic [CW-1:0]        wrap_dist;
    logic [CW-1:0]        ring_dist;
    logic [CW-1:0]        half_ext;
    logic [BW-1:0]        back_sum;
    logic [BW-1:0]        back;
    logic [CW-1:0]        posn_w;
    logic                 pair_conn;

    logic [FIELD_W-1:0]   neighbor_reg;
    logic [FIELD_W-1:0]   position_reg;
    logic                 connected_reg;
    logic                 outgoing_reg;
    logic                 err_reg;

    logic                 rsp_valid_reg;
    rsp_item_t            rsp_data_reg;
    logic                 out_free;

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= CFG_NC_W'(1);
            degree_reg     <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_NODE_COUNT)
            begin
                node_count_reg <= cfg_data[CFG_NC_W-1:0];
            end
            else if (cfg_index == CFG_DEGREE)
            begin
                degree_reg <= cfg_data[CFG_DEG_W-1:0];
            end
        end
    end

    // Clamp the node count to the table depth
    assign n_ext    = (CW'(node_count_reg) > CW'(MAX_NODES)) ? CW'(MAX_NODES)
                                                             : CW'(node_count_reg);
    assign n_live   = n_ext[NW-1:0];
    assign half     = degree_reg[CFG_DEG_W-1:1];
    assign half_ext = CW'(half);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= req_data;
        end
    end

    // Range checks on the request fields
    always_comb
    begin
        unique case (item_reg.operation)
            OP_LOAD:
                req_err = (CW'(item_reg.slot) >= n_ext) || (CW'(item_reg.label) >= n_ext);
            OP_NEIGHBOR:
                req_err = (CW'(item_reg.node_first) >= n_ext)
                       || (item_reg.neighbor_pos >= degree_reg);
            OP_PAIR:
                req_err = (CW'(item_reg.node_first) >= n_ext)
                       || (CW'(item_reg.node_second) >= n_ext);
            default:
                req_err = 1'b1;
        endcase
    end

    // Tables
    assign inv_raddr = cmd.inv_second ? AW'(item_reg.node_second) : AW'(item_reg.node_first);
    assign fwd_raddr = AW'(fwd_index);

    phnl_ram #(
        .WIDTH (FIELD_W),
        .DEPTH (MAX_NODES)
    ) u_fwd_ram (
        .clk   (clk),
        .we    (cmd.write_tables),
        .waddr (AW'(item_reg.slot)),
        .wdata (item_reg.label),
        .re    (cmd.fwd_rd),
        .raddr (fwd_raddr),
        .rdata (fwd_rdata)
    );

    phnl_ram #(
        .WIDTH (FIELD_W),
        .DEPTH (MAX_NODES)
    ) u_inv_ram (
        .clk   (clk),
        .we    (cmd.write_tables),
        .waddr (AW'(item_reg.label)),
        .wdata (item_reg.slot),
        .re    (cmd.inv_rd),
        .raddr (inv_raddr),
        .rdata (inv_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.latch_a)
        begin
            a_reg <= inv_rdata;
        end
        if (cmd.latch_b)
        begin
            b_reg <= inv_rdata;
        end
    end

    // Ring step: position + neighbour index - half, split into sign and magnitude
    assign step_sum = TW'(inv_rdata) + TW'(item_reg.neighbor_pos) - TW'(half);
    assign step_neg = step_sum[TW-1];
    assign step_abs = step_neg ? (~step_sum + TW'(1)) : step_sum;

    // Restoring remainder, one magnitude bit per cycle
    assign trial    = {rem_reg, mag_reg[MAG_W-1]};
    assign rem_next = (trial >= {1'b0, n_live}) ? NW'(trial - {1'b0, n_live})
                                                : trial[NW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            mag_reg <= step_abs[MAG_W-1:0];
            neg_reg <= step_neg;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            mag_reg <= {mag_reg[MAG_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    // Fold a negative step back onto the ring
    assign fwd_index = (neg_reg && (rem_reg != '0)) ? (n_live - rem_reg) : rem_reg;

    // Pair distance on the ring
    assign sub_ab    = (a_reg > b_reg) ? (a_reg - b_reg) : (b_reg - a_reg);
    assign sub_ext   = CW'(sub_ab);
    assign wrap_dist = n_ext - sub_ext;
    assign ring_dist = (wrap_dist < sub_ext) ? wrap_dist : sub_ext;
    assign pair_conn = (ring_dist <= half_ext);
    assign back_sum  = BW'(a_reg) + BW'(n_ext) - BW'(ring_dist);
    assign back      = (back_sum >= BW'(n_ext)) ? (back_sum - BW'(n_ext)) : back_sum;
    assign posn_w    = (back == BW'(b_reg)) ? (half_ext - ring_dist) : (half_ext + ring_dist);

    // Result under construction
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            neighbor_reg  <= '0;
            position_reg  <= '0;
            connected_reg <= 1'b0;
            outgoing_reg  <= 1'b0;
            err_reg       <= STATUS_OK;
        end
        if (cmd.set_err)
        begin
            err_reg <= STATUS_ERR;
        end
        if (cmd.latch_pair)
        begin
            position_reg  <= pair_conn ? posn_w[FIELD_W-1:0] : '0;
            connected_reg <= pair_conn;
            outgoing_reg  <= pair_conn && (posn_w >= half_ext);
        end
        if (cmd.latch_neighbor)
        begin
            neighbor_reg <= fwd_rdata;
        end
    end

    // Output register
    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rsp_data_reg.neighbor_node <= neighbor_reg;
            rsp_data_reg.position      <= position_reg;
            rsp_data_reg.connected     <= connected_reg;
            rsp_data_reg.outgoing      <= outgoing_reg;
            rsp_data_reg.status        <= err_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    assign sts.op       = item_reg.operation;
    assign sts.req_err  = req_err;
    assign sts.a_bad    = (CW'(inv_rdata) >= n_ext);
    assign sts.pair_bad = (CW'(a_reg) >= n_ext) || (CW'(b_reg) >= n_ext);
    assign sts.div_done = (div_cnt_reg == DIV_CNT_W'(MAG_W - 1));
    assign sts.out_free = out_free;

    `PHNL_ASSERT_SAME(a_emit_into_free, cmd.emit, out_free)
    `PHNL_ASSERT_NEXT(a_emit_shows, cmd.emit, rsp_valid_reg)
    `PHNL_ASSERT_SAME(a_rem_below_n, cmd.div_step, rem_reg < n_live)
    `PHNL_ASSERT_SAME(a_fwd_on_ring, cmd.fwd_rd, fwd_index < n_live)

endmodule

### verif/permuted_harary_neighbor_lookup_core_checker.sv
// ----------------------------------------------------------------------------
// permuted_harary_neighbor_lookup_core_checker
// Watches the config, request and result channels of the ring neighbour
// lookup, predicts every result from its own copy of the tables and
// registers, and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module permuted_harary_neighbor_lookup_core_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [phnl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [phnl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            req_valid,
    input  logic                            req_stall,
    input  phnl_pkg::req_item_t             req_data,
    input  logic                            rsp_valid,
    input  logic                            rsp_stall,
    input  phnl_pkg::rsp_item_t             rsp_data,
    output int                              mismatches,
    output int                              outstanding
);
    import phnl_pkg::*;

    localparam int TABLE_DEPTH = 1024;

    logic [FIELD_W-1:0]   fwd_map [TABLE_DEPTH];
    logic [FIELD_W-1:0]   inv_map [TABLE_DEPTH];
    logic [CFG_NC_W-1:0]  ring_nodes;
    logic [CFG_DEG_W-1:0] ring_degree;
    rsp_item_t            pending_results [$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Apply one transaction to the shadow tables and return its result
    function automatic rsp_item_t lookup_result(input req_item_t it);
        rsp_item_t res;
        int        live;
        int        half;
        int        p;
        int        t;
        int        r;
        int        a;
        int        b;
        int        sub;
        int        ring_dist;
        int        back;
        int        posn;
        res  = '0;
        live = (ring_nodes > CFG_NC_W'(TABLE_DEPTH)) ? TABLE_DEPTH : int'(ring_nodes);
        half = int'(ring_degree) >> 1;
        case (it.operation)
            OP_LOAD:
            begin
                if (it.slot >= live || it.label >= live)
                    res.status = STATUS_ERR;
                else
                begin
                    fwd_map[it.slot]  = it.label;
                    inv_map[it.label] = it.slot;
                end
            end
            OP_NEIGHBOR:
            begin
                if (it.node_first >= live || it.neighbor_pos >= ring_degree)
                    res.status = STATUS_ERR;
                else
                begin
                    p = int'(inv_map[it.node_first]);
                    if (p >= live)
                        res.status = STATUS_ERR;
                    else
                    begin
                        t = p + int'(it.neighbor_pos) - half;
                        r = t % live;
                        if (r < 0)
                            r += live;
                        res.neighbor_node = fwd_map[r];
                    end
                end
            end
            OP_PAIR:
            begin
                if (it.node_first >= live || it.node_second >= live)
                    res.status = STATUS_ERR;
                else
                begin
                    a = int'(inv_map[it.node_first]);
                    b = int'(inv_map[it.node_second]);
                    if (a >= live || b >= live)
                        res.status = STATUS_ERR;
                    else
                    begin
                        sub       = (a > b) ? a - b : b - a;
                        ring_dist = ((live - sub) < sub) ? live - sub : sub;
                        if (ring_dist <= half)
                        begin
                            back = (a + live - ring_dist) % live;
                            posn = (back == b) ? half - ring_dist : half + ring_dist;
                            res.position  = FIELD_W'(posn);
                            res.connected = 1'b1;
                            res.outgoing  = (posn >= half);
                        end
                    end
                end
            end
            default:
                res.status = STATUS_ERR;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_item_t want;
        if (!rst_n)
        begin
            ring_nodes  = CFG_NC_W'(1);
            ring_degree = '0;
            pending_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_NODE_COUNT: ring_nodes  = cfg_data[CFG_NC_W-1:0];
                    CFG_DEGREE:     ring_degree = cfg_data[CFG_DEG_W-1:0];
                    default: ;
                endcase
            end
            // Compare before pushing: a result never belongs to a same-edge request
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                    flag_mismatch("result with no transaction outstanding", 1, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp_data.neighbor_node !== want.neighbor_node)
                        flag_mismatch("neighbor_node", int'(rsp_data.neighbor_node),
                                      int'(want.neighbor_node));
                    if (rsp_data.position !== want.position)
                        flag_mismatch("position", int'(rsp_data.position),
                                      int'(want.position));
                    if (rsp_data.connected !== want.connected)
                        flag_mismatch("connected", int'(rsp_data.connected),
                                      int'(want.connected));
                    if (rsp_data.outgoing !== want.outgoing)
                        flag_mismatch("outgoing", int'(rsp_data.outgoing),
                                      int'(want.outgoing));
                    if (rsp_data.status !== want.status)
                        flag_mismatch("status", int'(rsp_data.status), int'(want.status));
                end
            end
            if (req_valid && !req_stall)
                pending_results.push_back(lookup_result(req_data));
        end
        outstanding = pending_results.size();
    end

endmodule

### verif/permuted_harary_neighbor_lookup_core_tb.sv
// ----------------------------------------------------------------------------
// permuted_harary_neighbor_lookup_core_tb
// Drives table loads, neighbour queries and pair queries into the lookup
// core under a series of node count and degree settings, with random gaps
// on requests and random result stalls; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module permuted_harary_neighbor_lookup_core_tb;

    import phnl_pkg::*;

    localparam int         TABLE_DEPTH = 1024;
    localparam int         ITEM_TARGET = 450;
    localparam int         IDLE_LIMIT  = 4000;
    localparam int         BACKLOG_LEN = 300;
    localparam int         TAIL_CYCLES = 24;
    // Operation code outside the enum, answered with an error
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  req_valid;
    logic                  req_stall;
    req_item_t             req_data;
    logic                  rsp_valid;
    logic                  rsp_stall;
    rsp_item_t             rsp_data;

    int mismatches;
    int outstanding;
    int requests_sent;
    int results_seen;
    int idle_cycles;
    int phases_run;
    bit calm;
    bit backlog_req;
    bit backlog_done;

    // Generator's view of which table entries hold data, so that no query
    // ever reads an entry that was never loaded
    logic [FIELD_W-1:0] gen_inv [TABLE_DEPTH];
    bit                 gen_inv_set [TABLE_DEPTH];
    bit                 gen_fwd_set [TABLE_DEPTH];
    int                 gen_nodes;
    int                 gen_degree;
    int                 loaded_labels [$];

    permuted_harary_neighbor_lookup_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    permuted_harary_neighbor_lookup_core_checker lookup_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_data    (req_data),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_data    (rsp_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Count results and watch for a hung channel
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            results_seen <= results_seen + 1;
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Receiver: random stalls, free stretches, and one long backlog on request
    initial
    begin
        int hold;
        int free;
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (backlog_req && !backlog_done)
            begin
                hold         = BACKLOG_LEN;
                backlog_done = 1'b1;
            end
            else
                hold = idle_gap();
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            free = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 100)
                                                : $urandom_range(1, 6);
            repeat (free - 1) @(posedge clk);
        end
    end

    function automatic int live_nodes();
        return (gen_nodes > TABLE_DEPTH) ? TABLE_DEPTH : gen_nodes;
    endfunction

    // True when the item touches only loaded table entries
    function automatic bit reads_loaded(input req_item_t c);
        int live;
        int p;
        int t;
        int r;
        live = live_nodes();
        case (c.operation)
            OP_NEIGHBOR:
            begin
                if (c.node_first >= live || c.neighbor_pos >= gen_degree)
                    return 1'b1;
                if (!gen_inv_set[c.node_first])
                    return 1'b0;
                p = int'(gen_inv[c.node_first]);
                if (p >= live)
                    return 1'b1;
                t = p + int'(c.neighbor_pos) - (gen_degree >> 1);
                r = t % live;
                if (r < 0)
                    r += live;
                return gen_fwd_set[r];
            end
            OP_PAIR:
            begin
                if (c.node_first >= live || c.node_second >= live)
                    return 1'b1;
                return gen_inv_set[c.node_first] && gen_inv_set[c.node_second];
            end
            default:
                return 1'b1;
        endcase
    endfunction

    // Track a load that the block will take
    function automatic void note_item(input req_item_t c);
        int live;
        live = live_nodes();
        if (c.operation == OP_LOAD && c.slot < live && c.label < live)
        begin
            gen_fwd_set[c.slot]  = 1'b1;
            gen_inv_set[c.label] = 1'b1;
            gen_inv[c.label]     = c.slot;
            loaded_labels.push_back(int'(c.label));
        end
    endfunction

    function automatic req_item_t mk(input logic [1:0] op, input int slot, input int label,
                                     input int n1, input int n2, input int pos);
        req_item_t c;
        c.operation    = op;
        c.slot         = FIELD_W'(slot);
        c.label        = FIELD_W'(label);
        c.node_first   = FIELD_W'(n1);
        c.node_second  = FIELD_W'(n2);
        c.neighbor_pos = FIELD_W'(pos);
        return c;
    endfunction

    // Offer one transaction and hold it until accepted; valid stays high
    // afterwards so that the next caller decides its level in this step
    task automatic offer(input req_item_t item);
        int gap;
        gap = calm ? 0 : idle_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        note_item(item);
        req_valid <= 1'b1;
        req_data  <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        requests_sent++;
    endtask

    // Drop valid and wait until every result has come back
    task automatic drain();
        req_valid <= 1'b0;
        while (results_seen != requests_sent)
            @(posedge clk);
    endtask

    // Write both registers; call only when the block is idle
    task automatic set_config(input int nodes, input int deg_data);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NODE_COUNT;
        cfg_data  <= CFG_DATA_W'(nodes);
        @(posedge clk);
        cfg_index <= CFG_DEGREE;
        cfg_data  <= CFG_DATA_W'(deg_data);
        @(posedge clk);
        cfg_we    <= 1'b0;
        gen_nodes  = nodes;
        gen_degree = deg_data & 10'h3FF;
    endtask

    function automatic int pick_node();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80 && loaded_labels.size() > 0)
            return loaded_labels[$urandom_range(0, loaded_labels.size() - 1)];
        if (pick < 95)
            return $urandom_range(0, live_nodes());
        return $urandom_range(0, TABLE_DEPTH - 1);
    endfunction

    // Build a query mix; retry until it reads only loaded entries, else fall back to the unused code
    function automatic req_item_t pick_query();
        req_item_t c;
        int        pick;
        for (int tries = 0; tries < 16; tries++)
        begin
            c    = mk(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
                      $urandom);
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                c.operation  = OP_NEIGHBOR;
                c.node_first = FIELD_W'(pick_node());
                if ($urandom_range(0, 9) != 0)
                    c.neighbor_pos = FIELD_W'($urandom_range(0, gen_degree));
            end
            else if (pick < 82)
            begin
                c.operation   = OP_PAIR;
                c.node_first  = FIELD_W'(pick_node());
                c.node_second = ($urandom_range(0, 6) == 0) ? c.node_first
                                                            : FIELD_W'(pick_node());
            end
            else if (pick < 92)
            begin
                c.operation = OP_LOAD;
                c.slot      = FIELD_W'($urandom_range(0, live_nodes()));
                c.label     = FIELD_W'($urandom_range(0, live_nodes()));
            end
            else if (pick < 96)
                c.operation = OP_UNUSED;
            if (reads_loaded(c))
                return c;
        end
        c.operation = OP_UNUSED;
        return c;
    endfunction

    // Load the ring: a whole permutation for small rings, a window around
    // slot zero for large ones
    task automatic fill_ring();
        int live;
        int perm [$];
        int j;
        int swap;
        live = live_nodes();
        if (live == 0)
            return;
        if (live <= 32)
        begin
            for (int i = 0; i < live; i++)
                perm.push_back(i);
            for (int i = live - 1; i > 0; i--)
            begin
                j       = $urandom_range(0, i);
                swap    = perm[i];
                perm[i] = perm[j];
                perm[j] = swap;
            end
            for (int i = 0; i < live; i++)
                offer(mk(OP_LOAD, i, perm[i], 0, 0, 0));
        end
        else
        begin
            for (int k = 0; k < 32; k++)
                offer(mk(OP_LOAD, (live - 8 + k) % live, $urandom_range(0, live - 1),
                         0, 0, 0));
        end
    endtask

    task automatic directed_items();
        // Reset setting: one node, degree zero
        offer(mk(OP_LOAD, 0, 0, 0, 0, 0));
        offer(mk(OP_LOAD, 1, 0, 0, 0, 0));          // slot past the ring
        offer(mk(OP_PAIR, 0, 0, 0, 0, 0));          // same node twice
        offer(mk(OP_NEIGHBOR, 0, 0, 0, 0, 0));      // no position below degree zero
        offer(mk(OP_UNUSED, 1023, 1023, 1023, 1023, 1023));
        // Empty ring: everything is refused
        drain();
        set_config(0, 5);
        offer(mk(OP_LOAD, 0, 0, 0, 0, 0));
        offer(mk(OP_PAIR, 0, 0, 0, 0, 0));
        // Reversed ring of eight
        drain();
        set_config(8, 4);
        for (int i = 0; i < 8; i++)
            offer(mk(OP_LOAD, i, 7 - i, 0, 0, 0));
        offer(mk(OP_NEIGHBOR, 0, 0, 2, 0, 0));
        offer(mk(OP_NEIGHBOR, 0, 0, 7, 0, 3));
        offer(mk(OP_NEIGHBOR, 0, 0, 7, 0, 4));      // position at degree
        offer(mk(OP_NEIGHBOR, 0, 0, 8, 0, 0));      // node past the ring
        offer(mk(OP_PAIR, 0, 0, 3, 3, 0));
        offer(mk(OP_PAIR, 0, 0, 0, 6, 0));          // two apart, connected
        offer(mk(OP_PAIR, 0, 0, 0, 4, 0));          // opposite, not connected
        offer(mk(OP_PAIR, 0, 0, 0, 1023, 0));
        // Shrink to four: inverse entries left over point past the ring,
        // and the degree reaches round the ring many times
        drain();
        set_config(4, 1023);
        offer(mk(OP_NEIGHBOR, 0, 0, 0, 0, 0));
        offer(mk(OP_PAIR, 0, 0, 1, 2, 0));
        offer(mk(OP_LOAD, 0, 0, 0, 0, 0));
        offer(mk(OP_NEIGHBOR, 0, 0, 0, 0, 1000));
        offer(mk(OP_NEIGHBOR, 0, 0, 0, 0, 2));
    endtask

    initial
    begin
        int nodes;
        int deg_data;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        req_valid     = 1'b0;
        req_data      = '0;
        requests_sent = 0;
        results_seen  = 0;
        idle_cycles   = 0;
        phases_run    = 0;
        calm          = 1'b0;
        backlog_req   = 1'b0;
        backlog_done  = 1'b0;
        gen_nodes     = 1;
        gen_degree    = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            gen_inv_set[i] = 1'b0;
            gen_fwd_set[i] = 1'b0;
            gen_inv[i]     = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_items();

        // Random phases, each behind a full drain and a fresh setting
        while (requests_sent < ITEM_TARGET || phases_run < 8)
        begin
            case (phases_run % 8)
                0:
                begin
                    nodes    = $urandom_range(2, 16);
                    deg_data = $urandom_range(0, 2 * nodes);
                end
                1:
                begin
                    nodes    = TABLE_DEPTH;
                    deg_data = $urandom_range(0, 12);
                end
                2:
                begin
                    nodes    = 2047;
                    deg_data = 1023;
                end
                3:
                begin
                    nodes    = $urandom_range(1, 3);
                    deg_data = $urandom_range(0, 1023);
                end
                4:
                begin
                    nodes    = $urandom_range(17, 32);
                    deg_data = $urandom_range(0, 40);
                end
                5:
                begin
                    // Oversized count acts as the full table; bit ten of the
                    // degree write falls outside the register
                    nodes    = $urandom_range(1025, 2047);
                    deg_data = $urandom_range(0, 16) | ($urandom_range(0, 1) << 10);
                end
                6:
                begin
                    nodes    = $urandom_range(2, 16);
                    deg_data = 0;
                end
                default:
                begin
                    nodes    = 0;
                    deg_data = $urandom_range(0, 1023);
                end
            endcase
            calm = (phases_run % 3 == 0);
            drain();
            set_config(nodes, deg_data);
            fill_ring();
            // Ask the receiver for its long hold while queries keep coming
            if (phases_run == 4)
                backlog_req = 1'b1;
            for (int q = 0; q < 30; q++)
                offer(pick_query());
            phases_run++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Ran %0d transactions over %0d random ring settings after the directed set",
                 requests_sent, phases_run);
        $display("Loads, neighbour and pair queries, range errors and stale entries checked");
        if (mismatches == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/phnl_pkg.sv
hw/rtl/phnl_ram.sv
hw/rtl/phnl_ctrl.sv
hw/rtl/phnl_dp.sv
hw/rtl/permuted_harary_neighbor_lookup_core.sv
verif/permuted_harary_neighbor_lookup_core_checker.sv
verif/permuted_harary_neighbor_lookup_core_tb.sv
